[hw/rtl/lpl_pkg.sv]
// Shared types and constants for the linked peak limiter.
// No dependencies; imported by linked_peak_limiter.
`default_nettype none

package lpl_pkg;

	// default build parameters
	localparam int DEF_CHANNELS    = 2;
	localparam int DEF_SAMPLE_BITS = 24;

	// fixed field widths
	localparam int ENV_BITS   = 24;
	localparam int GAIN_BITS  = 17;
	localparam int COEF_BITS  = 16;
	localparam int CEIL_BITS  = 23;
	localparam int QUO_BITS   = 16;
	localparam int FRAC_BITS  = 16;

	// register port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 23;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CH_COUNT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTH   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CEILING  = 3'd5;

	localparam logic [GAIN_BITS-1:0] GAIN_UNITY     = 17'h10000;
	localparam logic [FRAC_BITS-1:0] ROUND_HALF     = 16'h8000;
	localparam logic [CEIL_BITS-1:0] CEIL_RESET     = 23'h7FFFFF;
	localparam logic [1:0]           CH_COUNT_RESET = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PEAK,
		ST_ENV_GO,
		ST_ENV,
		ST_ENV_WB,
		ST_DIV_GO,
		ST_DIV,
		ST_GAIN_GO,
		ST_GAIN,
		ST_GAIN_WB,
		ST_APPLY_GO,
		ST_APPLY,
		ST_APPLY_WB,
		ST_DONE
	} state_t;

	// operand source for the shared shift-add unit
	typedef enum logic [1:0] {
		MAC_ENV,
		MAC_GAIN,
		MAC_APPLY
	} mac_sel_t;

	// sequencer strobes into the datapath
	typedef struct packed {
		logic     mac_start;
		mac_sel_t mac_sel;
		logic     div_start;
		logic     peak_load;
		logic     env_load;
		logic     target_load;
		logic     target_from_div;
		logic     gain_load;
		logic     res_load;
		logic     out_load;
	} ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/linked_peak_limiter.sv]
// Linked stereo peak limiter, top level. Uses lpl_pkg, lpl_mac, lpl_div.
// A new frame is taken only in the idle state, once the last result is loaded into the
// output register. Each frame runs three 17-step shift-add passes, plus the 16-step
// divider when the envelope is over the ceiling; a disabled limiter passes it through.
// Reset (arst_n low, async): limiter off, two channels, coefficients 0, ceiling
// full scale, envelope 0, smoothed gain unity, no result pending.
`default_nettype none

module linked_peak_limiter #(
	parameter int CHANNELS    = lpl_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS = lpl_pkg::DEF_SAMPLE_BITS,
	localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * SAMPLE_BITS + lpl_pkg::GAIN_BITS + 7) / 8) * 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input frames
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [IN_W-1:0]                    s_tdata,   // sample_ch0, sample_ch1
	// limited frames
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [OUT_W-1:0]                        m_tdata,   // out_ch0, out_ch1, applied_gain
	// register writes
	input  wire logic                               cfg_we,
	input  wire logic [lpl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [lpl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import lpl_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	// common width of envelope and peak magnitude
	localparam int MW   = (SAMPLE_BITS > ENV_BITS) ? SAMPLE_BITS : ENV_BITS;
	localparam int OW   = MW + 1;          // signed operand of the shift-add unit
	localparam int AW   = OW + GAIN_BITS;  // its product width
	localparam int TW   = AW + 1;          // product plus offset and rounding

	// ---------------- configuration registers ----------------
	logic                 en_q;
	logic [1:0]           cc_q;
	logic [COEF_BITS-1:0] atk_q;
	logic [COEF_BITS-1:0] rel_q;
	logic [COEF_BITS-1:0] smo_q;
	logic [CEIL_BITS-1:0] ceil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			cc_q   <= CH_COUNT_RESET;
			atk_q  <= '0;
			rel_q  <= '0;
			smo_q  <= '0;
			ceil_q <= CEIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:   en_q   <= cfg_data[0];
				CFG_CH_COUNT: cc_q   <= cfg_data[1:0];
				CFG_ATTACK:   atk_q  <= cfg_data[COEF_BITS-1:0];
				CFG_RELEASE:  rel_q  <= cfg_data[COEF_BITS-1:0];
				CFG_SMOOTH:   smo_q  <= cfg_data[COEF_BITS-1:0];
				CFG_CEILING:  ceil_q <= cfg_data[CEIL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// counts 0 and 1 mean one channel, 2 and 3 mean two, capped by the build
	logic two_ch;
	assign two_ch = (CHANNELS > 1) ? cc_q[1] : 1'b0;

	// ---------------- sequencer ----------------
	state_t state_q, state_d;
	ctrl_t  ctrl;
	logic   accept;
	logic   mac0_busy, mac1_busy, div_busy;
	logic   over_ceil;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = en_q ? ST_PEAK : ST_DONE;
			ST_PEAK:     state_d = ST_ENV_GO;
			ST_ENV_GO:   state_d = ST_ENV;
			ST_ENV:      if (!mac0_busy) state_d = ST_ENV_WB;
			ST_ENV_WB:   state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = over_ceil ? ST_DIV : ST_GAIN_GO;
			ST_DIV:      if (!div_busy) state_d = ST_GAIN_GO;
			ST_GAIN_GO:  state_d = ST_GAIN;
			ST_GAIN:     if (!mac0_busy) state_d = ST_GAIN_WB;
			ST_GAIN_WB:  state_d = ST_APPLY_GO;
			ST_APPLY_GO: state_d = ST_APPLY;
			ST_APPLY:    if (!mac0_busy && !mac1_busy) state_d = ST_APPLY_WB;
			ST_APPLY_WB: state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mac_sel = MAC_ENV;
		unique case (state_q)
			ST_PEAK:     ctrl.peak_load = 1'b1;
			ST_ENV_GO: begin
				ctrl.mac_start = 1'b1;
				ctrl.mac_sel   = MAC_ENV;
			end
			ST_ENV_WB:   ctrl.env_load = 1'b1;
			ST_DIV_GO: begin
				ctrl.div_start   = over_ceil;
				ctrl.target_load = !over_ceil;
			end
			ST_DIV: begin
				ctrl.target_load     = !div_busy;
				ctrl.target_from_div = 1'b1;
			end
			ST_GAIN_GO: begin
				ctrl.mac_start = 1'b1;
				ctrl.mac_sel   = MAC_GAIN;
			end
			ST_GAIN_WB:  ctrl.gain_load = 1'b1;
			ST_APPLY_GO: begin
				ctrl.mac_start = 1'b1;
				ctrl.mac_sel   = MAC_APPLY;
			end
			ST_APPLY_WB: ctrl.res_load = 1'b1;
			ST_DONE:     ctrl.out_load = out_free;
			default: begin
			end
		endcase
	end

	// ---------------- frame and state registers ----------------
	logic        [SB-1:0]        x0, x1;
	logic        [SB-1:0]        mag0, mag1;
	logic        [SB-1:0]        x0_q, x1_q;
	logic        [SB-1:0]        mag0_q, mag1_q;
	logic        [SB-1:0]        peak_q;
	logic        [ENV_BITS-1:0]  env_q;
	logic        [GAIN_BITS-1:0] gain_q;
	logic        [GAIN_BITS-1:0] target_q;
	logic        [SB-1:0]        res_y0_q, res_y1_q;
	logic        [GAIN_BITS-1:0] res_g_q;

	assign x0   = s_tdata[SB-1:0];
	assign x1   = s_tdata[2*SB-1:SB];
	// most negative code maps to 2^(SB-1), which still fits unsigned
	assign mag0 = x0[SB-1] ? (~x0 + 1'b1) : x0;
	assign mag1 = x1[SB-1] ? (~x1 + 1'b1) : x1;

	// ---------------- shift-add unit operands ----------------
	logic        [MW-1:0]        env_ext, peak_ext;
	logic                        rising;
	logic signed [OW-1:0]        env_diff;
	logic        [GAIN_BITS:0]   gain_diff;
	logic signed [OW-1:0]        mac0_op;
	logic        [GAIN_BITS-1:0] mac0_coef;
	logic signed [OW-1:0]        mac1_op;
	logic signed [AW-1:0]        acc0, acc1;
	logic        [QUO_BITS-1:0]  quo;

	assign env_ext   = MW'(env_q);
	assign peak_ext  = MW'(peak_q);
	assign rising    = (peak_ext > env_ext);
	// pole rewritten as peak + a*(env - peak), so one product per update
	assign env_diff  = OW'(env_ext) - OW'(peak_ext);
	assign gain_diff = {1'b0, gain_q} - {1'b0, target_q};
	assign over_ceil = (env_q > {1'b0, ceil_q});
	assign mac1_op   = {{(OW-SB){1'b0}}, mag1_q};

	always_comb begin
		unique case (ctrl.mac_sel)
			MAC_ENV: begin
				mac0_op   = env_diff;
				mac0_coef = {1'b0, rising ? atk_q : rel_q};
			end
			MAC_GAIN: begin
				mac0_op   = {{(OW-GAIN_BITS-1){gain_diff[GAIN_BITS]}}, gain_diff};
				mac0_coef = {1'b0, smo_q};
			end
			MAC_APPLY: begin
				mac0_op   = {{(OW-SB){1'b0}}, mag0_q};
				mac0_coef = gain_q;
			end
			default: begin
				mac0_op   = '0;
				mac0_coef = '0;
			end
		endcase
	end

	lpl_mac #(
		.OP_BITS (OW),
		.COEF_W  (GAIN_BITS)
	) u_mac0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctrl.mac_start),
		.operand (mac0_op),
		.coeff   (mac0_coef),
		.acc     (acc0),
		.busy    (mac0_busy)
	);

	// second lane only runs while the gain is applied
	lpl_mac #(
		.OP_BITS (OW),
		.COEF_W  (GAIN_BITS)
	) u_mac1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctrl.mac_start && (ctrl.mac_sel == MAC_APPLY)),
		.operand (mac1_op),
		.coeff   (gain_q),
		.acc     (acc1),
		.busy    (mac1_busy)
	);

	lpl_div #(
		.NUM_W (CEIL_BITS),
		.DEN_W (ENV_BITS),
		.QUO_W (QUO_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (ceil_q),
		.den    (env_q),
		.quo    (quo),
		.busy   (div_busy)
	);

	// ---------------- result arithmetic ----------------
	logic [TW-1:0] env_sum, gain_sum;
	logic [AW-1:0] prod0, prod1;
	logic [SB-1:0] r0, r1;

	// sum is never negative, so the selected bits are the new value
	assign env_sum  = {acc0[AW-1], acc0} + TW'({peak_q, {FRAC_BITS{1'b0}}}) + TW'(ROUND_HALF);
	assign gain_sum = {acc0[AW-1], acc0} + TW'({target_q, {FRAC_BITS{1'b0}}})
		+ TW'(ROUND_HALF);
	assign prod0    = acc0 + AW'(ROUND_HALF);
	assign prod1    = acc1 + AW'(ROUND_HALF);
	assign r0       = prod0[FRAC_BITS +: SB];
	assign r1       = prod1[FRAC_BITS +: SB];

	// clamp magnitude to full scale, then restore the sign
	function automatic logic [SB-1:0] limit(input logic [SB-1:0] r, input logic neg);
		logic [SB-1:0] m;
		m = r[SB-1] ? {1'b0, {(SB-1){1'b1}}} : r;
		return neg ? (~m + 1'b1) : m;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			gain_q <= GAIN_UNITY;
		end else begin
			if (ctrl.env_load) env_q <= env_sum[FRAC_BITS +: ENV_BITS];
			if (ctrl.gain_load) gain_q <= gain_sum[FRAC_BITS +: GAIN_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q   <= x0;
			x1_q   <= x1;
			mag0_q <= mag0;
			mag1_q <= mag1;
			if (!en_q) begin
				// bypass: samples go out as they came, the second zeroed when one channel is set
				res_y0_q <= x0;
				res_y1_q <= two_ch ? x1 : '0;
				res_g_q  <= GAIN_UNITY;
			end
		end
		if (ctrl.peak_load) peak_q <= (two_ch && (mag1_q > mag0_q)) ? mag1_q : mag0_q;
		if (ctrl.target_load) target_q <= ctrl.target_from_div ? {1'b0, quo} : GAIN_UNITY;
		if (ctrl.res_load) begin
			res_y0_q <= limit(r0, x0_q[SB-1]);
			res_y1_q <= two_ch ? limit(r1, x1_q[SB-1]) : '0;
			res_g_q  <= gain_q;
		end
	end

	// ---------------- output word register ----------------
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) m_tdata_q <= OUT_W'({res_g_q, res_y1_q, res_y0_q});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

[hw/rtl/lpl_mac.sv]
// Bit-serial signed multiplier: operand times an unsigned coefficient,
// one coefficient bit per cycle, MSB first. Uses no package items.
`default_nettype none

module lpl_mac #(
	parameter int OP_BITS = 25,
	parameter int COEF_W  = 17
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [OP_BITS-1:0]     operand,
	input  wire logic        [COEF_W-1:0]      coeff,
	output logic signed      [OP_BITS+COEF_W-1:0] acc,
	output logic                               busy
);
	localparam int ACC_BITS = OP_BITS + COEF_W;
	localparam int CNT_BITS = $clog2(COEF_W + 1);

	logic signed [OP_BITS-1:0]  op_q;
	logic        [COEF_W-1:0]   bits_q;
	logic        [CNT_BITS-1:0] cnt_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [ACC_BITS-1:0] addend;

	assign addend = bits_q[COEF_W-1] ? {{COEF_W{op_q[OP_BITS-1]}}, op_q} : '0;
	assign busy   = (cnt_q != '0);
	assign acc    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(COEF_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			bits_q <= coeff;
			acc_q  <= '0;
		end else if (busy) begin
			acc_q  <= (acc_q <<< 1) + addend;
			bits_q <= bits_q << 1;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lpl_div.sv]
// Restoring divider, one quotient bit per cycle: quo = (num << QUO_W) / den.
// Needs num < den at start. Uses no package items.
`default_nettype none

module lpl_div #(
	parameter int NUM_W = 23,
	parameter int DEN_W = 24,
	parameter int QUO_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo,
	output logic                  busy
);
	localparam int CNT_BITS = $clog2(QUO_W + 1);

	logic [DEN_W-1:0]    rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [QUO_W-1:0]    quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_W:0]      shifted;
	logic [DEN_W:0]      diff;
	logic                ge;

	assign shifted = {rem_q, 1'b0};
	assign ge      = (shifted >= {1'b0, den_q});
	assign diff    = shifted - {1'b0, den_q};
	assign busy    = (cnt_q != '0);
	assign quo     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(QUO_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder stays below den, so the low DEN_W bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num);
			den_q <= den;
			quo_q <= '0;
		end else if (busy) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire
